@@ src/utf8_pkg.sv @@
// Package for the UTF-8 stream decoder: status codes, decode constants and
// the sequence state type. It has no dependencies.
package utf8_pkg;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_MORE      = 2'd1;
  localparam logic [1:0] ST_BAD       = 2'd2;
  localparam logic [1:0] ST_BAD_RETRY = 2'd3;

  localparam int CP_W   = 21;
  localparam int MIN_W  = 17;
  localparam int BYTE_W = 8;

  localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;
  localparam logic [CP_W-1:0] SURR_LO        = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI        = 21'h00DFFF;
  localparam logic [CP_W-1:0] MAX_CP         = 21'h10FFFF;

  // Lead byte boundaries
  localparam logic [BYTE_W-1:0] LEAD2_LO   = 8'hC2;
  localparam logic [BYTE_W-1:0] LEAD3_LO   = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD4_LO   = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD4_END  = 8'hF5;

  // Smallest legal value per sequence length
  localparam logic [MIN_W-1:0] MIN2 = 17'h00080;
  localparam logic [MIN_W-1:0] MIN3 = 17'h00800;
  localparam logic [MIN_W-1:0] MIN4 = 17'h10000;

  // State of a pending multi-byte sequence
  typedef struct packed {
    logic [CP_W-1:0]  partial_value;
    logic [MIN_W-1:0] minimum_value;
    logic [1:0]       bytes_expected;
    logic [1:0]       bytes_seen;
  } dec_state_t;

  localparam dec_state_t STATE_CLEAR = '0;

endpackage

@@ src/utf8_stream_decoder.sv @@
// Pipeline: two register stages, input byte then result; a request accepted into
// the input stage moves on to the result register when that is free or draining.
// Throughput: one byte per cycle while out_ready is high; a stalled result holds the input stage.
// Reset: synchronous active-low rst_n clears both stages and the sequence state.
// UTF-8 stream decoder top level. Depends on utf8_pkg.
module utf8_stream_decoder
  import utf8_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [CP_W-1:0]   out_code_point
);

  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_adv;

  dec_state_t        state_r, state_nxt;
  logic              out_valid_r;
  logic [1:0]        out_status_r, status_nxt;
  logic [CP_W-1:0]   out_code_point_r, code_point_nxt;

  logic [CP_W-1:0]   shifted;
  logic [1:0]        seen_inc;
  logic              legal;

  // Advance the input stage when the result register is free or being drained
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  // Decode one byte against the pending sequence
  assign shifted  = {state_r.partial_value[CP_W-7:0], s1_byte_r[5:0]};
  assign seen_inc = state_r.bytes_seen + 2'd1;
  assign legal    = (shifted >= {4'd0, state_r.minimum_value})
                 && !((shifted >= SURR_LO) && (shifted <= SURR_HI))
                 && (shifted <= MAX_CP);

  always_comb begin
    state_nxt      = state_r;
    status_nxt     = ST_BAD;
    code_point_nxt = REPLACEMENT_CP;
    if (state_r.bytes_expected != 2'd0) begin
      if (s1_byte_r[7:6] != 2'b10) begin
        // Abandon the sequence; caller re-feeds this byte
        state_nxt  = STATE_CLEAR;
        status_nxt = ST_BAD_RETRY;
      end else if (seen_inc < state_r.bytes_expected) begin
        state_nxt.partial_value = shifted;
        state_nxt.bytes_seen    = seen_inc;
        status_nxt              = ST_MORE;
      end else begin
        state_nxt = STATE_CLEAR;
        if (legal) begin
          status_nxt     = ST_OK;
          code_point_nxt = shifted;
        end else begin
          status_nxt = ST_BAD;
        end
      end
    end else if (!s1_byte_r[7]) begin
      status_nxt     = ST_OK;
      code_point_nxt = {{(CP_W-BYTE_W){1'b0}}, s1_byte_r};
    end else if (s1_byte_r < LEAD2_LO) begin
      status_nxt = ST_BAD;
    end else if (s1_byte_r < LEAD3_LO) begin
      state_nxt.partial_value  = {{(CP_W-5){1'b0}}, s1_byte_r[4:0]};
      state_nxt.minimum_value  = MIN2;
      state_nxt.bytes_expected = 2'd1;
      state_nxt.bytes_seen     = 2'd0;
      status_nxt               = ST_MORE;
    end else if (s1_byte_r < LEAD4_LO) begin
      state_nxt.partial_value  = {{(CP_W-4){1'b0}}, s1_byte_r[3:0]};
      state_nxt.minimum_value  = MIN3;
      state_nxt.bytes_expected = 2'd2;
      state_nxt.bytes_seen     = 2'd0;
      status_nxt               = ST_MORE;
    end else if (s1_byte_r < LEAD4_END) begin
      state_nxt.partial_value  = {{(CP_W-3){1'b0}}, s1_byte_r[2:0]};
      state_nxt.minimum_value  = MIN4;
      state_nxt.bytes_expected = 2'd3;
      state_nxt.bytes_seen     = 2'd0;
      status_nxt               = ST_MORE;
    end else begin
      status_nxt = ST_BAD;
    end
  end

  // Capture the incoming request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_byte;
    end
  end

  // Update sequence state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= STATE_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        state_r <= state_nxt;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_status_r     <= status_nxt;
      out_code_point_r <= code_point_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_code_point = out_code_point_r;

  // Non-OK results always carry the replacement character
  a_repl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ST_OK)) |-> (out_code_point_r == REPLACEMENT_CP))
    else $error("non-OK result without replacement code point");

  // OK results are scalar values
  a_scalar: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == ST_OK)) |->
      ((out_code_point_r <= MAX_CP) &&
       !((out_code_point_r >= SURR_LO) && (out_code_point_r <= SURR_HI))))
    else $error("OK result is not a scalar value");

  // Continuation count never reaches the expected count while pending
  a_seen: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.bytes_expected == 2'd0) ? (state_r.bytes_seen == 2'd0)
                                     : (state_r.bytes_seen < state_r.bytes_expected))
    else $error("sequence counters out of step");

  // A result held under stall is not overwritten
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> ($stable(out_status_r) && $stable(out_code_point_r)))
    else $error("stalled result overwritten");

endmodule

@@ tb/sv/utf8_stream_decoder_tb.sv @@
`timescale 1ns / 100ps
// Testbench for utf8_stream_decoder: directed and random byte streams, with
// every result checked against a built-in decoder model. Depends on utf8_pkg.
module utf8_stream_decoder_tb
  import utf8_pkg::*;
();

  typedef struct packed {
    logic [1:0]      status;
    logic [CP_W-1:0] code_point;
  } decode_result_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [BYTE_W-1:0] in_byte;
  logic              out_valid;
  logic              out_ready;
  logic [1:0]        out_status;
  logic [CP_W-1:0]   out_code_point;

  // Decoder model state
  logic [CP_W-1:0]  seq_value;
  logic [MIN_W-1:0] seq_min;
  logic [1:0]       seq_need;
  logic [1:0]       seq_seen;

  decode_result_t pending_results[$];
  int             mismatches;
  int             bytes_sent;
  int             send_idle_pct;
  int             recv_stall_pct;

  utf8_stream_decoder u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_code_point (out_code_point)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the result side at random
  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic clear_sequence();
    seq_value = '0;
    seq_min   = '0;
    seq_need  = 2'd0;
    seq_seen  = 2'd0;
  endtask

  // Advance the model by one byte and queue the result it must produce
  task automatic predict_decode(input logic [BYTE_W-1:0] b);
    decode_result_t r;
    logic [CP_W-1:0] v;
    r.status     = ST_OK;
    r.code_point = REPLACEMENT_CP;
    if (seq_need != 2'd0) begin
      if (b[7:6] != 2'b10) begin
        // A non-continuation byte abandons the pending sequence
        clear_sequence();
        r.status = ST_BAD_RETRY;
      end else begin
        seq_value = {seq_value[CP_W-7:0], b[5:0]};
        seq_seen  = seq_seen + 2'd1;
        if (seq_seen < seq_need) begin
          r.status = ST_MORE;
        end else begin
          v = seq_value;
          if (v < seq_min || (v >= SURR_LO && v <= SURR_HI) || v > MAX_CP) begin
            r.status = ST_BAD;
          end else begin
            r.code_point = v;
          end
          clear_sequence();
        end
      end
    end else if (b < 8'h80) begin
      r.code_point = {{(CP_W-BYTE_W){1'b0}}, b};
    end else if (b < LEAD2_LO || b >= LEAD4_END) begin
      r.status = ST_BAD;
    end else if (b < LEAD3_LO) begin
      seq_value = {16'd0, b[4:0]};
      seq_min   = MIN2;
      seq_need  = 2'd1;
      seq_seen  = 2'd0;
      r.status  = ST_MORE;
    end else if (b < LEAD4_LO) begin
      seq_value = {17'd0, b[3:0]};
      seq_min   = MIN3;
      seq_need  = 2'd2;
      seq_seen  = 2'd0;
      r.status  = ST_MORE;
    end else begin
      seq_value = {18'd0, b[2:0]};
      seq_min   = MIN4;
      seq_need  = 2'd3;
      seq_seen  = 2'd0;
      r.status  = ST_MORE;
    end
    pending_results.push_back(r);
  endtask

  // Send one request; returns at the edge where it is accepted
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      in_byte  = 8'($urandom);
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_byte  = b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_decode(b);
    bytes_sent++;
  endtask

  // Drop valid and hold until every queued result has come back
  task automatic hold_until_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic send_string(input logic [BYTE_W-1:0] seq[$]);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // Encode a scalar value into a well-formed sequence of the given length
  task automatic send_code_point(input logic [CP_W-1:0] cp, input int len);
    case (len)
      1: begin
        send_byte(cp[7:0]);
      end
      2: begin
        send_byte({3'b110, cp[10:6]});
        send_byte({2'b10, cp[5:0]});
      end
      3: begin
        send_byte({4'b1110, cp[15:12]});
        send_byte({2'b10, cp[11:6]});
        send_byte({2'b10, cp[5:0]});
      end
      default: begin
        send_byte({5'b11110, cp[20:18]});
        send_byte({2'b10, cp[17:12]});
        send_byte({2'b10, cp[11:6]});
        send_byte({2'b10, cp[5:0]});
      end
    endcase
  endtask

  task automatic test_ascii();
    send_string('{8'h00, 8'h7F});
  endtask

  // Smallest two-byte value, largest scalar value
  task automatic test_multibyte();
    send_string('{8'hC2, 8'h80});
    send_string('{8'hF4, 8'h8F, 8'hBF, 8'hBF});
  endtask

  // Overlong, surrogate and above-range values fail on the final byte
  task automatic test_bad_values();
    send_string('{8'hE0, 8'h80, 8'h80});
    send_string('{8'hED, 8'hA0, 8'h80});
    send_string('{8'hF4, 8'h90, 8'h80, 8'h80});
  endtask

  task automatic test_invalid_leads();
    send_string('{8'h80, 8'hC1, 8'hF5, 8'hFF});
  endtask

  // Break a sequence with an ASCII byte, then re-feed it
  task automatic test_interrupted_sequence();
    send_string('{8'hC3, 8'h41, 8'h41});
  endtask

  // Mostly well-formed text, plus bad values, broken sequences and noise
  task automatic test_random_traffic(input int n_bytes, input int idle_pct,
                                     input int stall_pct);
    int start;
    int pick;
    int len;
    int need;
    int k;
    logic [CP_W-1:0]   cp;
    logic [BYTE_W-1:0] lead;
    logic [BYTE_W-1:0] brk;
    bit paused;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start  = bytes_sent;
    paused = 1'b0;
    while (bytes_sent - start < n_bytes) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        len = $urandom_range(4, 1);
        case (len)
          1:       cp = 21'($urandom_range(21'h7F, 21'h0));
          2:       cp = 21'($urandom_range(21'h7FF, 21'h80));
          3:       cp = 21'($urandom_range(21'hFFFF, 21'h800));
          default: cp = 21'($urandom_range(21'h10FFFF, 21'h10000));
        endcase
        send_code_point(cp, len);
      end else begin
        lead = 8'($urandom_range(8'hF4, 8'hC2));
        need = (lead >= LEAD4_LO) ? 3 : (lead >= LEAD3_LO) ? 2 : 1;
        if (pick < 75) begin
          // Right length, arbitrary payload bits
          send_byte(lead);
          for (k = 0; k < need; k++) send_byte({2'b10, 6'($urandom)});
        end else if (pick < 90) begin
          send_byte(lead);
          for (k = $urandom_range(need - 1, 0); k > 0; k--) begin
            send_byte({2'b10, 6'($urandom)});
          end
          brk = 8'($urandom_range(191, 0));
          if (brk >= 8'h80) brk = brk + 8'h40;
          send_byte(brk);
          if ($urandom_range(1)) send_byte(brk);
        end else begin
          send_byte(8'($urandom));
        end
      end
      // Pause once mid-phase until the result side has caught up
      if (!paused && bytes_sent - start >= n_bytes / 2) begin
        paused = 1'b1;
        hold_until_drained();
      end
    end
  endtask

  // Compare each accepted result with the oldest expected one
  always @(posedge clk) begin : check_results
    decode_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: status %0d code_point %h",
                 $time, out_status, out_code_point);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status mismatch: expected %0d, got %0d",
                   $time, want.status, out_status);
          mismatches++;
        end
        if (out_code_point !== want.code_point) begin
          $display("%0t: code_point mismatch: expected %h, got %h",
                   $time, want.code_point, out_code_point);
          mismatches++;
        end
      end
    end
  end

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_byte        = '0;
    out_ready      = 1'b0;
    mismatches     = 0;
    bytes_sent     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    clear_sequence();
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_ascii();
    test_multibyte();
    test_bad_values();
    test_invalid_leads();
    test_interrupted_sequence();
    test_random_traffic(475, 0, 0);
    test_random_traffic(475, 60, 0);
    test_random_traffic(475, 0, 60);
    test_random_traffic(475, 20, 20);

    // Drain, then let the pipeline settle before the verdict
    hold_until_drained();
    repeat (5) @(negedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("utf8_stream_decoder_tb: PASS");
    end else begin
      $display("utf8_stream_decoder_tb: FAIL");
    end
    $finish;
  end

  // Timeout guard
  initial begin
    #2000000;
    $display("utf8_stream_decoder_tb: FAIL");
    $finish;
  end

endmodule
